// ===== rtl/bpiq_pkg.sv =====
// Shared types, constants and codes of the button and pot input qualifier.
package bpiq_pkg;

  // Panel size and counter width.
  localparam int NUM_BUTTONS  = 16;
  localparam int NUM_KNOBS    = 8;
  localparam int NUM_SLIDERS  = 2;
  localparam int ONTIME_WIDTH = 16;

  // Derived index widths; the play button sits after the step buttons.
  localparam int NUM_BTN_CH = NUM_BUTTONS + 1;
  localparam int BTN_IDX_W  = $clog2(NUM_BTN_CH);
  localparam int KNOB_IDX_W = $clog2(NUM_KNOBS);
  localparam int SLD_IDX_W  = (NUM_SLIDERS > 1) ? $clog2(NUM_SLIDERS) : 1;

  // Field widths.
  localparam int CH_W       = 5;
  localparam int RAW_W      = 10;
  localparam int LEVEL_W    = 7;
  localparam int PROD_W     = RAW_W + LEVEL_W;
  localparam int WIGGLE_W   = 4;
  localparam int CLOCK_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Knob channels with their own rules.
  localparam int KNOB_FIXED_CH = 3;
  localparam int KNOB_ZERO_CH  = 6;

  // Analog scaling: raw * LEVEL_RANGE / LEVEL_FULL_SCALE.
  localparam int LEVEL_RANGE      = 100;
  localparam int LEVEL_FULL_SCALE = 1023;

  // Slider wiggle counter.
  localparam int WIGGLE_MAX     = 15;
  localparam int WIGGLE_TRIGGER = 6;
  localparam int WIGGLE_STEP_UP = 2;

  // Register reset values.
  localparam int DEBOUNCE_RESET      = 10;
  localparam int LONG_PRESS_RESET    = 500;
  localparam int CHANGE_THR_RESET    = 1;
  localparam int BIG_CHANGE_RESET    = 30;
  localparam int DOUBLE_WINDOW_RESET = 500;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_BUTTON = 2'd1,
    OP_KNOB   = 2'd2,
    OP_SLIDER = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE       = 3'd0,
    CFG_LONG_PRESS     = 3'd1,
    CFG_CHANGE_THR     = 3'd2,
    CFG_BIG_CHANGE_THR = 3'd3,
    CFG_DOUBLE_WINDOW  = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_STEP   = 3'd1,
    CMD_PLAY   = 3'd2,
    CMD_KNOB   = 3'd3,
    CMD_SLIDER = 3'd4
  } cmd_e;

  typedef struct packed {
    op_e              op;
    logic [CH_W-1:0]  channel;
    logic             pressed;
    logic [RAW_W-1:0] raw_level;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]     which;
    logic                held;
    logic                quick_press;
    logic                double_press;
    logic [LEVEL_W-1:0]  value;
    logic                changed;
    logic [WIGGLE_W-1:0] wiggle_count;
    logic                wiggle_trigger;
  } out_item_t;

  typedef struct packed {
    logic [7:0]         debounce_ms;
    logic [15:0]        long_press_ms;
    logic [LEVEL_W-1:0] change_threshold;
    logic [LEVEL_W-1:0] big_change_threshold;
    logic [15:0]        double_press_window_ms;
  } cfg_t;

  typedef struct packed {
    cmd_e               kind;
    logic [CH_W-1:0]    channel;
    logic               pressed;
    logic [LEVEL_W-1:0] level;
  } cmd_t;

endpackage

// ===== rtl/button_pot_input_qualifier.sv =====
// Top level of the control panel input qualifier: register file and front/back wiring.
//
// Usage: input items (ms tick, button sample, knob sample, slider sample) arrive on
// the in_valid_i/in_ready_o channel as in_item_i. A tick updates the ms clock and the
// button on-time counters and gives no result; every other item with a channel in
// range gives one result on out_valid_o/out_ready_i as out_item_o. Items with a
// channel out of range are taken and dropped.
// Throughput is one item per cycle while the receiver takes results. Each item is
// written into the command queue at its transfer in, and the execution stage then
// loads the result register from the queue head. The two-entry queue and the result
// register let input transfers continue while a result waits.
// When the receiver stalls, the result register holds and the queue fills; once it
// is full, in_ready_o drops. A tick at the queue head still drains while a result waits.
// Configuration writes on cfg_valid_i/cfg_ready_o are always taken; indexes beyond
// the register list are ignored. Reset clears all panel state and loads the default
// register values; the block is ready as soon as reset ends.
module button_pot_input_qualifier (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  bpiq_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output bpiq_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bpiq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bpiq_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  bpiq_pkg::cfg_t cfg_q;
  logic           q_full;
  logic           q_push;
  bpiq_pkg::cmd_t q_push_data;
  logic           q_pop;
  logic           q_valid;
  bpiq_pkg::cmd_t q_head;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms            <= 8'(bpiq_pkg::DEBOUNCE_RESET);
      cfg_q.long_press_ms          <= 16'(bpiq_pkg::LONG_PRESS_RESET);
      cfg_q.change_threshold       <= bpiq_pkg::LEVEL_W'(bpiq_pkg::CHANGE_THR_RESET);
      cfg_q.big_change_threshold   <= bpiq_pkg::LEVEL_W'(bpiq_pkg::BIG_CHANGE_RESET);
      cfg_q.double_press_window_ms <= 16'(bpiq_pkg::DOUBLE_WINDOW_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bpiq_pkg::CFG_DEBOUNCE:       cfg_q.debounce_ms <= cfg_data_i[7:0];
        bpiq_pkg::CFG_LONG_PRESS:     cfg_q.long_press_ms <= cfg_data_i;
        bpiq_pkg::CFG_CHANGE_THR: begin
          cfg_q.change_threshold <= cfg_data_i[bpiq_pkg::LEVEL_W-1:0];
        end
        bpiq_pkg::CFG_BIG_CHANGE_THR: begin
          cfg_q.big_change_threshold <= cfg_data_i[bpiq_pkg::LEVEL_W-1:0];
        end
        bpiq_pkg::CFG_DOUBLE_WINDOW:  cfg_q.double_press_window_ms <= cfg_data_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Front end: accept and classify.
  bpiq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .cmd_o      (q_push_data)
  );

  // Command queue.
  bpiq_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // Back end: execute and report.
  bpiq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .cmd_i       (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/bpiq_front.sv =====
// Front end: accepts input items, drops bad channels, scales analog samples.
module bpiq_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bpiq_pkg::in_item_t in_item_i,
  input  logic               q_full_i,
  output logic               push_o,
  output bpiq_pkg::cmd_t     cmd_o
);

  logic                              keep;
  logic [bpiq_pkg::PROD_W-1:0]       prod;
  logic [bpiq_pkg::LEVEL_W-1:0]      quot0;
  logic [bpiq_pkg::RAW_W:0]          rem;
  logic [bpiq_pkg::LEVEL_W-1:0]      level;
  logic [31:0]                       ch_ext;

  // The queue has room, so the item can be taken.
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o && keep;
  assign ch_ext     = 32'(in_item_i.channel);

  // Scale to 0..100: x / 1023 = x / 1024 plus one where the remainder reaches 1023.
  assign prod  = bpiq_pkg::PROD_W'(in_item_i.raw_level) *
                 bpiq_pkg::PROD_W'(bpiq_pkg::LEVEL_RANGE);
  assign quot0 = prod[bpiq_pkg::PROD_W-1:bpiq_pkg::RAW_W];
  assign rem   = (bpiq_pkg::RAW_W+1)'(prod[bpiq_pkg::RAW_W-1:0]) +
                 (bpiq_pkg::RAW_W+1)'(quot0);
  assign level = quot0 + bpiq_pkg::LEVEL_W'(rem >=
                 (bpiq_pkg::RAW_W+1)'(bpiq_pkg::LEVEL_FULL_SCALE));

  // Classify the item; channels out of range for their op are dropped.
  always_comb begin
    keep          = 1'b0;
    cmd_o.kind    = bpiq_pkg::CMD_TICK;
    cmd_o.channel = in_item_i.channel;
    cmd_o.pressed = in_item_i.pressed;
    cmd_o.level   = level;
    unique case (in_item_i.op)
      bpiq_pkg::OP_TICK: begin
        keep = 1'b1;
      end
      bpiq_pkg::OP_BUTTON: begin
        if (ch_ext < 32'(bpiq_pkg::NUM_BUTTONS)) begin
          keep       = 1'b1;
          cmd_o.kind = bpiq_pkg::CMD_STEP;
        end else if (ch_ext == 32'(bpiq_pkg::NUM_BUTTONS)) begin
          keep       = 1'b1;
          cmd_o.kind = bpiq_pkg::CMD_PLAY;
        end
      end
      bpiq_pkg::OP_KNOB: begin
        if (ch_ext < 32'(bpiq_pkg::NUM_KNOBS)) begin
          keep       = 1'b1;
          cmd_o.kind = bpiq_pkg::CMD_KNOB;
        end
      end
      bpiq_pkg::OP_SLIDER: begin
        if (ch_ext < 32'(bpiq_pkg::NUM_SLIDERS)) begin
          keep       = 1'b1;
          cmd_o.kind = bpiq_pkg::CMD_SLIDER;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // A scaled level never exceeds the top of the range.
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (cmd_o.level <= bpiq_pkg::LEVEL_W'(bpiq_pkg::LEVEL_RANGE)))
    else $error("scaled level above range");

endmodule

// ===== rtl/bpiq_fifo.sv =====
// Short command queue between the front end and the execution back end.
module bpiq_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bpiq_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output bpiq_pkg::cmd_t head_o
);

  bpiq_pkg::cmd_t              mem_q [bpiq_pkg::QUEUE_DEPTH];
  logic [bpiq_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [bpiq_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [bpiq_pkg::QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == bpiq_pkg::QCNT_W'(bpiq_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == bpiq_pkg::QPTR_W'(bpiq_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == bpiq_pkg::QPTR_W'(bpiq_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // The fill count stays within the depth and is never pushed past full.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bpiq_pkg::QCNT_W'(bpiq_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop_i) |-> !push_i)
    else $error("push into a full queue");

endmodule

// ===== rtl/bpiq_back.sv =====
// Back end: executes queued commands against the panel state, drives the result register.
module bpiq_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpiq_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  bpiq_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bpiq_pkg::out_item_t out_item_o
);

  logic [bpiq_pkg::ONTIME_WIDTH-1:0] on_time_q [bpiq_pkg::NUM_BTN_CH];
  logic [bpiq_pkg::ONTIME_WIDTH-1:0] on_time_d [bpiq_pkg::NUM_BTN_CH];
  logic [bpiq_pkg::NUM_BTN_CH-1:0]   debounced_q, debounced_d;
  logic [bpiq_pkg::LEVEL_W-1:0]      knob_q [bpiq_pkg::NUM_KNOBS];
  logic [bpiq_pkg::LEVEL_W-1:0]      knob_d [bpiq_pkg::NUM_KNOBS];
  logic [bpiq_pkg::LEVEL_W-1:0]      slider_q [bpiq_pkg::NUM_SLIDERS];
  logic [bpiq_pkg::LEVEL_W-1:0]      slider_d [bpiq_pkg::NUM_SLIDERS];
  logic [bpiq_pkg::WIGGLE_W-1:0]     wiggle_q [bpiq_pkg::NUM_SLIDERS];
  logic [bpiq_pkg::WIGGLE_W-1:0]     wiggle_d [bpiq_pkg::NUM_SLIDERS];
  logic [bpiq_pkg::CLOCK_W-1:0]      ms_clock_q, ms_clock_d;
  logic [bpiq_pkg::CLOCK_W-1:0]      last_quick_q, last_quick_d;

  logic                              out_valid_q;
  bpiq_pkg::out_item_t               out_q;
  logic                              res_valid;
  bpiq_pkg::out_item_t               res;

  logic [bpiq_pkg::BTN_IDX_W-1:0]    btn_idx;
  logic [bpiq_pkg::KNOB_IDX_W-1:0]   knob_idx;
  logic [bpiq_pkg::SLD_IDX_W-1:0]    sld_idx;
  logic [bpiq_pkg::ONTIME_WIDTH-1:0] ot;
  logic [31:0]                       ot_ext;
  logic                              above_debounce;
  logic                              below_long;
  logic                              step_quick;
  logic                              play_quick;
  logic [bpiq_pkg::CLOCK_W-1:0]      since_quick;
  logic                              in_window;
  logic [bpiq_pkg::LEVEL_W-1:0]      knob_prev;
  logic [bpiq_pkg::LEVEL_W-1:0]      knob_diff;
  logic                              knob_moved;
  logic [bpiq_pkg::LEVEL_W-1:0]      sld_prev;
  logic [bpiq_pkg::LEVEL_W-1:0]      sld_diff;
  logic                              sld_moved;
  logic [bpiq_pkg::LEVEL_W-1:0]      sld_new;
  logic [bpiq_pkg::WIGGLE_W-1:0]     wig;
  logic [bpiq_pkg::WIGGLE_W:0]       wig_up;
  logic [bpiq_pkg::WIGGLE_W-1:0]     wig_new;
  logic                              slot_free;

  // A tick needs no result slot; everything else waits for a free one.
  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop_o       = q_valid_i && (slot_free || (cmd_i.kind == bpiq_pkg::CMD_TICK));
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Channel indexes and the reads of the addressed entries.
  assign btn_idx   = bpiq_pkg::BTN_IDX_W'(cmd_i.channel);
  assign knob_idx  = bpiq_pkg::KNOB_IDX_W'(cmd_i.channel);
  assign sld_idx   = bpiq_pkg::SLD_IDX_W'(cmd_i.channel);
  assign ot        = on_time_q[btn_idx];
  assign knob_prev = knob_q[knob_idx];
  assign sld_prev  = slider_q[sld_idx];
  assign wig       = wiggle_q[sld_idx];

  // Button timing compares.
  assign ot_ext         = 32'(ot);
  assign above_debounce = ot_ext > 32'(cfg_i.debounce_ms);
  assign below_long     = ot_ext < 32'(cfg_i.long_press_ms);
  assign step_quick     = !cmd_i.pressed && debounced_q[btn_idx] && below_long;
  assign play_quick     = step_quick && above_debounce;
  assign since_quick    = ms_clock_q - last_quick_q;
  assign in_window      = since_quick < bpiq_pkg::CLOCK_W'(cfg_i.double_press_window_ms);

  // Deadband compares for knobs and sliders.
  assign knob_diff  = (cmd_i.level > knob_prev) ? cmd_i.level - knob_prev :
                      knob_prev - cmd_i.level;
  assign knob_moved = knob_diff > cfg_i.change_threshold;
  assign sld_diff   = (cmd_i.level > sld_prev) ? cmd_i.level - sld_prev :
                      sld_prev - cmd_i.level;
  assign sld_moved  = sld_diff > cfg_i.change_threshold;
  assign sld_new    = sld_moved ? cmd_i.level : sld_prev;

  // Wiggle counter: up by two on a big registered swing, else down by one.
  assign wig_up = (bpiq_pkg::WIGGLE_W+1)'(wig) +
                  (bpiq_pkg::WIGGLE_W+1)'(bpiq_pkg::WIGGLE_STEP_UP);
  always_comb begin
    if (sld_moved && (sld_diff > cfg_i.big_change_threshold)) begin
      wig_new = (wig_up > (bpiq_pkg::WIGGLE_W+1)'(bpiq_pkg::WIGGLE_MAX)) ?
                bpiq_pkg::WIGGLE_W'(bpiq_pkg::WIGGLE_MAX) : wig_up[bpiq_pkg::WIGGLE_W-1:0];
    end else begin
      wig_new = (wig == '0) ? '0 : wig - 1'b1;
    end
  end

  // Execute the command at the queue head.
  always_comb begin
    on_time_d    = on_time_q;
    debounced_d  = debounced_q;
    knob_d       = knob_q;
    slider_d     = slider_q;
    wiggle_d     = wiggle_q;
    ms_clock_d   = ms_clock_q;
    last_quick_d = last_quick_q;
    res          = '0;
    res.which    = cmd_i.channel;
    res_valid    = 1'b0;
    if (pop_o) begin
      unique case (cmd_i.kind)
        bpiq_pkg::CMD_TICK: begin
          ms_clock_d = ms_clock_q + 1'b1;
          for (int j = 0; j < bpiq_pkg::NUM_BTN_CH; j++) begin
            if (on_time_q[j] != '1) begin
              on_time_d[j] = on_time_q[j] + 1'b1;
            end
          end
        end
        bpiq_pkg::CMD_STEP: begin
          res_valid       = 1'b1;
          res.quick_press = step_quick;
          if (!cmd_i.pressed) begin
            on_time_d[btn_idx] = '0;
            res.held           = 1'b0;
          end else begin
            res.held = above_debounce;
          end
          debounced_d[btn_idx] = res.held;
        end
        bpiq_pkg::CMD_PLAY: begin
          res_valid        = 1'b1;
          res.quick_press  = play_quick;
          res.double_press = play_quick && in_window;
          res.held         = cmd_i.pressed && above_debounce;
          if (play_quick) begin
            last_quick_d = ms_clock_q;
          end
          if (!cmd_i.pressed) begin
            on_time_d[btn_idx] = '0;
          end
          debounced_d[btn_idx] = res.held;
        end
        bpiq_pkg::CMD_KNOB: begin
          res_valid = 1'b1;
          if (32'(cmd_i.channel) == 32'(bpiq_pkg::KNOB_FIXED_CH)) begin
            knob_d[knob_idx] = cmd_i.level;
            res.value        = cmd_i.level;
            res.changed      = 1'b0;
          end else if (32'(cmd_i.channel) == 32'(bpiq_pkg::KNOB_ZERO_CH)) begin
            knob_d[knob_idx] = cmd_i.level;
            res.value        = cmd_i.level;
            res.changed      = (cmd_i.level == '0) && (knob_prev != '0);
          end else begin
            res.changed = knob_moved;
            res.value   = knob_moved ? cmd_i.level : knob_prev;
            if (knob_moved) begin
              knob_d[knob_idx] = cmd_i.level;
            end
          end
        end
        bpiq_pkg::CMD_SLIDER: begin
          res_valid          = 1'b1;
          slider_d[sld_idx]  = sld_new;
          wiggle_d[sld_idx]  = wig_new;
          res.value          = sld_new;
          res.changed        = sld_moved;
          res.wiggle_count   = wig_new;
          res.wiggle_trigger = wig_new > bpiq_pkg::WIGGLE_W'(bpiq_pkg::WIGGLE_TRIGGER);
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  // Panel state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < bpiq_pkg::NUM_BTN_CH; j++) begin
        on_time_q[j] <= '0;
      end
      for (int j = 0; j < bpiq_pkg::NUM_KNOBS; j++) begin
        knob_q[j] <= '0;
      end
      for (int j = 0; j < bpiq_pkg::NUM_SLIDERS; j++) begin
        slider_q[j] <= '0;
        wiggle_q[j] <= '0;
      end
      debounced_q  <= '0;
      ms_clock_q   <= '0;
      last_quick_q <= '0;
    end else begin
      on_time_q    <= on_time_d;
      knob_q       <= knob_d;
      slider_q     <= slider_d;
      wiggle_q     <= wiggle_d;
      debounced_q  <= debounced_d;
      ms_clock_q   <= ms_clock_d;
      last_quick_q <= last_quick_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  // A double press is always a quick press, and a quick press is never held.
  a_double_is_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.double_press) |-> out_q.quick_press)
    else $error("double press without quick press");
  a_quick_not_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.held && out_q.quick_press))
    else $error("quick press reported while held");
  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && (cmd_i.kind == bpiq_pkg::CMD_TICK)) |=>
    (ms_clock_q == $past(ms_clock_q) + 1'b1))
    else $error("tick did not advance the ms clock");

endmodule
